[src/sppw_pkg.sv]
// shared types and constants for the servo power to pulse width mapper
`timescale 1ns / 1ps
`default_nettype none

package sppw_pkg;

    localparam int WIDTH_W    = 30;
    localparam int CTRL_W     = 16;
    localparam int DUTY_W     = 7;
    localparam int NUM_W      = 52;
    localparam int DEN_W      = 30;
    localparam int CNT_W      = 6;
    localparam int DUTY_NUM_W = 37;
    localparam int CFG_IDX_W  = 3;

    localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 30'd1000000000;
    localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;
    localparam logic [CNT_W-1:0]   WIDTH_BITS  = 6'd52;
    localparam logic [CNT_W-1:0]   DUTY_BITS   = 6'd37;

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STOP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CLO    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHI    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INV    = 3'd7;

    localparam logic OP_SET_POWER = 1'b0;
    localparam logic OP_POWER_OFF = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic signed [CTRL_W-1:0] power_value;
        logic                     clamp_enable;
    } t_in;

    typedef struct packed {
        logic [WIDTH_W-1:0]       pulse_width_ns;
        logic                     running;
        logic signed [CTRL_W-1:0] power_now;
        logic [DUTY_W-1:0]        duty_percent;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [CNT_W-1:0] bits;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

`default_nettype wire

[src/servo_power_to_pulse_width.sv]
// servo power to pulse width mapper, top level with sequencer and registers
// set power runs prep, multiply, a width division of 52 divider steps,
// saturate, a duty division of 37 steps and saturate, one bit per cycle each
// in the shared divider; a zero span or zero period skips its division;
// power off goes straight to output; one word in flight, a new word taken
// only when idle, which waits while a result stalls; synchronous active low
// reset loads register defaults and clears run state
`timescale 1ns / 1ps
`default_nettype none

module servo_power_to_pulse_width
    import sppw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in                  i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out                      o_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WIDTH_W-1:0]   i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_DIV1 = 4'd3;
    localparam logic [3:0] S_SAT1 = 4'd4;
    localparam logic [3:0] S_DUTY = 4'd5;
    localparam logic [3:0] S_DIV2 = 4'd6;
    localparam logic [3:0] S_SAT2 = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_DIV0 = 4'd9;

    // configuration
    logic [WIDTH_W-1:0]       r_period, r_min, r_max, r_zero, r_stop;
    logic signed [CTRL_W-1:0] r_clo, r_chi;
    logic                     r_inv;

    // sequencer and state
    logic [3:0]               r_state;
    logic                     r_op;
    logic signed [CTRL_W-1:0] r_val;
    logic signed [19:0]       r_delta;
    logic signed [30:0]       r_range;
    logic signed [16:0]       r_span;
    logic signed [NUM_W-1:0]  r_prod;
    logic [WIDTH_W-1:0]       r_width;
    logic [DUTY_W-1:0]        r_dnew;
    logic [DUTY_W-1:0]        r_duty;
    logic                     r_o_valid;
    t_out                     r_o_data;

    t_div_req div_req;
    t_div_rsp div_rsp;

    sppw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // clamp, high bound tested first
    logic signed [CTRL_W-1:0] clamped;
    always_comb begin
        clamped = i_data.power_value;
        if (i_data.clamp_enable) begin
            if (i_data.power_value > r_chi)      clamped = r_chi;
            else if (i_data.power_value < r_clo) clamped = r_clo;
        end
    end

    logic [WIDTH_W-1:0] stop_sat;
    assign stop_sat = (r_stop > WIDTH_MAX) ? WIDTH_MAX : r_stop;

    // midpoint truncated toward zero, then mirror and offset
    logic signed [16:0] sum17, mean17;
    logic signed [19:0] mean20, v20, vm20, delta20;
    logic signed [30:0] range31;
    logic signed [16:0] span17;
    always_comb begin
        sum17   = {r_clo[CTRL_W-1], r_clo} + {r_chi[CTRL_W-1], r_chi};
        mean17  = $signed(sum17 + 17'(sum17[16])) >>> 1;
        mean20  = {{3{mean17[16]}}, mean17};
        v20     = {{4{r_val[CTRL_W-1]}}, r_val};
        vm20    = r_inv ? ((mean20 <<< 1) - v20) : v20;
        delta20 = vm20 - mean20;
        range31 = (vm20 <= mean20) ? ($signed({1'b0, r_zero}) - $signed({1'b0, r_min}))
                                   : ($signed({1'b0, r_max}) - $signed({1'b0, r_zero}));
        span17  = {r_chi[CTRL_W-1], r_chi} - {r_clo[CTRL_W-1], r_clo};
    end

    logic signed [50:0] prod51;
    assign prod51 = r_delta * r_range;

    logic             prod_neg;
    logic [NUM_W-1:0] prod_mag;
    logic [16:0]      span_mag;
    assign prod_neg = r_prod[NUM_W-1];
    assign prod_mag = prod_neg ? NUM_W'(-r_prod) : r_prod;
    assign span_mag = r_span[16] ? 17'(-r_span) : r_span;

    // signed quotient added to zero width, then saturated
    logic               q_neg;
    logic signed [53:0] q54, w54;
    logic [WIDTH_W-1:0] width_sat;
    always_comb begin
        q_neg = prod_neg ^ r_span[16];
        q54   = q_neg ? -$signed({2'b00, div_rsp.quot}) : $signed({2'b00, div_rsp.quot});
        w54   = $signed({24'd0, r_zero}) + q54;
        if (w54[53])                     width_sat = '0;
        else if (w54 > 54'(WIDTH_MAX))   width_sat = WIDTH_MAX;
        else                             width_sat = w54[WIDTH_W-1:0];
    end

    logic [DUTY_NUM_W-1:0] duty_num;
    assign duty_num = DUTY_NUM_W'(r_width) * DUTY_NUM_W'(DUTY_MAX);

    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = {prod_mag};
        div_req.bits  = WIDTH_BITS;
        div_req.den   = DEN_W'(span_mag);
        case (r_state)
            S_DIV0: begin
                div_req.start = (r_span != '0);
            end
            S_DUTY: begin
                div_req.start = (r_period != '0);
                div_req.num   = {duty_num, {(NUM_W-DUTY_NUM_W){1'b0}}};
                div_req.bits  = DUTY_BITS;
                div_req.den   = r_period;
            end
            default: ;
        endcase
    end

    logic in_acc, out_free;
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= 30'd20000000;
            r_min     <= 30'd1000000;
            r_max     <= 30'd2000000;
            r_zero    <= 30'd1500000;
            r_stop    <= '0;
            r_clo     <= -16'sd100;
            r_chi     <= 16'sd100;
            r_inv     <= 1'b0;
            r_state   <= S_IDLE;
            r_duty    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_PERIOD: r_period <= i_cfg_data;
                    REG_MIN:    r_min    <= i_cfg_data;
                    REG_MAX:    r_max    <= i_cfg_data;
                    REG_ZERO:   r_zero   <= i_cfg_data;
                    REG_STOP:   r_stop   <= i_cfg_data;
                    REG_CLO:    r_clo    <= i_cfg_data[CTRL_W-1:0];
                    REG_CHI:    r_chi    <= i_cfg_data[CTRL_W-1:0];
                    REG_INV:    r_inv    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if ((r_state == S_OUT) && out_free) r_o_valid <= 1'b1;
            else if (!i_stall)                  r_o_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_data.operation;
                        r_val <= clamped;
                        if (i_data.operation == OP_POWER_OFF) begin
                            r_width <= stop_sat;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_delta <= delta20;
                    r_range <= range31;
                    r_span  <= span17;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= {prod51, 1'b0};
                    r_state <= S_DIV0;
                end
                S_DIV0: begin
                    r_state <= S_DIV1;
                end
                S_DIV1: begin
                    // zero span skips the divider and drives the zero width
                    if (r_span == '0) begin
                        r_width <= (r_zero > WIDTH_MAX) ? WIDTH_MAX : r_zero;
                        r_state <= S_DUTY;
                    end else if (div_rsp.done) begin
                        r_state <= S_SAT1;
                    end
                end
                S_SAT1: begin
                    r_width <= width_sat;
                    r_state <= S_DUTY;
                end
                S_DUTY: begin
                    if (r_period == '0) begin
                        r_dnew  <= DUTY_MAX;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (div_rsp.done) r_state <= S_SAT2;
                end
                S_SAT2: begin
                    r_dnew  <= (div_rsp.quot > NUM_W'(DUTY_MAX)) ? DUTY_MAX
                                                                 : div_rsp.quot[DUTY_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_o_data.pulse_width_ns <= r_width;
                        if (r_op == OP_POWER_OFF) begin
                            r_o_data.running      <= 1'b0;
                            r_o_data.power_now    <= '0;
                            r_o_data.duty_percent <= r_duty;
                        end else begin
                            r_duty  <= r_dnew;
                            r_o_data.running      <= 1'b1;
                            r_o_data.power_now    <= r_val;
                            r_o_data.duty_percent <= r_dnew;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule

`default_nettype wire

[src/sppw_div.sv]
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module sppw_div
    import sppw_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_nq;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic             qbit;
    logic [DEN_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_nq[NUM_W-1]};
        qbit  = (trial >= {1'b0, r_den});
        n_rem = qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.bits;
                r_rem  <= '0;
                r_nq   <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_nq  <= {r_nq[NUM_W-2:0], qbit};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_nq;

endmodule

`default_nettype wire

[tb/servo_power_to_pulse_width_tb.sv]
// self-checking testbench for the servo power to pulse width mapper
`timescale 1ns / 1ps

module servo_power_to_pulse_width_tb;
    import sppw_pkg::*;

    localparam int QUIET_LIMIT     = 20000;
    localparam int RANDOM_PHASES   = 16;
    localparam int WORDS_PER_PHASE = 125;

    logic                 i_clk     = 1'b0;
    logic                 i_rst_n   = 1'b0;
    logic                 drv_valid = 1'b0;
    t_in                  drv_data  = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [WIDTH_W-1:0]   cfg_data  = '0;
    logic                 o_stall;
    logic                 o_valid;
    t_out                 o_data;

    // local copy of the registers, loaded with their reset values
    logic [WIDTH_W-1:0]       period_ns  = 30'd20000000;
    logic [WIDTH_W-1:0]       min_ns     = 30'd1000000;
    logic [WIDTH_W-1:0]       max_ns     = 30'd2000000;
    logic [WIDTH_W-1:0]       zero_ns    = 30'd1500000;
    logic [WIDTH_W-1:0]       stop_ns    = 30'd0;
    logic signed [CTRL_W-1:0] ctrl_low   = -16'sd100;
    logic signed [CTRL_W-1:0] ctrl_high  = 16'sd100;
    logic                     invert     = 1'b0;

    // servo state as the block should hold it
    logic                     run_flag   = 1'b0;
    logic signed [CTRL_W-1:0] power_held = '0;
    logic [DUTY_W-1:0]        duty_held  = '0;

    t_in  pending_q[$];
    t_out expected_q[$];
    t_out want;

    int   send_gap_pct   = 0;
    int   recv_stall_pct = 0;
    int   errors         = 0;
    int   quiet_cycles   = 0;
    logic in_taken       = 1'b0;

    servo_power_to_pulse_width dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (drv_valid),
        .o_stall    (o_stall),
        .i_data     (drv_data),
        .o_valid    (o_valid),
        .i_stall    (out_stall),
        .o_data     (o_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // expected pulse word for one command, updates the held servo state
    function automatic t_out predict_pulse(t_in w);
        longint v, lo, hi, mid, delta, slope, span, width, duty;
        t_out   r;
        if (w.operation == OP_POWER_OFF) begin
            width      = longint'(stop_ns);
            run_flag   = 1'b0;
            power_held = '0;
        end else begin
            v  = w.power_value;
            lo = ctrl_low;
            hi = ctrl_high;
            // high bound is tested first, which matters for swapped bounds
            if (w.clamp_enable) begin
                if (v > hi)
                    v = hi;
                else if (v < lo)
                    v = lo;
            end
            power_held = v[CTRL_W-1:0];
            mid = (lo + hi) / 2;
            if (invert)
                v = 2 * mid - v;
            delta = v - mid;
            if (v <= mid)
                slope = longint'(zero_ns) - longint'(min_ns);
            else
                slope = longint'(max_ns) - longint'(zero_ns);
            span = hi - lo;
            if (span == 0)
                width = longint'(zero_ns);
            else
                width = longint'(zero_ns) + (delta * slope * 2) / span;
            run_flag = 1'b1;
        end
        if (width < 0)
            width = 0;
        else if (width > longint'(WIDTH_MAX))
            width = longint'(WIDTH_MAX);
        if (w.operation == OP_SET_POWER) begin
            if (period_ns == '0) begin
                duty_held = DUTY_MAX;
            end else begin
                duty = (100 * width) / longint'(period_ns);
                if (duty > 100)
                    duty = 100;
                duty_held = duty[DUTY_W-1:0];
            end
        end
        r.pulse_width_ns = width[WIDTH_W-1:0];
        r.running        = run_flag;
        r.power_now      = power_held;
        r.duty_percent   = duty_held;
        return r;
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width();
        case ($urandom_range(6))
            0:       return '0;
            1:       return WIDTH_MAX;
            2:       return '1;
            3:       return WIDTH_W'($urandom_range(2500000, 500000));
            4:       return WIDTH_W'($urandom);
            default: return WIDTH_W'($urandom_range(1000000000));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_PERIOD: period_ns = data;
            REG_MIN:    min_ns    = data;
            REG_MAX:    max_ns    = data;
            REG_ZERO:   zero_ns   = data;
            REG_STOP:   stop_ns   = data;
            REG_CLO:    ctrl_low  = data[CTRL_W-1:0];
            REG_CHI:    ctrl_high = data[CTRL_W-1:0];
            REG_INV:    invert    = data[0];
            default: ;
        endcase
    endtask

    // unused upper bits of the narrow registers get random junk
    task automatic set_config(input logic [WIDTH_W-1:0] per, input logic [WIDTH_W-1:0] mn,
                              input logic [WIDTH_W-1:0] mx, input logic [WIDTH_W-1:0] zr,
                              input logic [WIDTH_W-1:0] st, input logic [CTRL_W-1:0] lo,
                              input logic [CTRL_W-1:0] hi, input logic inv);
        logic [WIDTH_W-CTRL_W-1:0] junk_ctrl;
        logic [WIDTH_W-2:0]        junk_inv;
        write_reg(REG_PERIOD, per);
        write_reg(REG_MIN, mn);
        write_reg(REG_MAX, mx);
        write_reg(REG_ZERO, zr);
        write_reg(REG_STOP, st);
        junk_ctrl = $urandom;
        write_reg(REG_CLO, {junk_ctrl, lo});
        junk_ctrl = $urandom;
        write_reg(REG_CHI, {junk_ctrl, hi});
        junk_inv = $urandom;
        write_reg(REG_INV, {junk_inv, inv});
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_word(input logic op, input logic [CTRL_W-1:0] val, input logic clamp);
        t_in w;
        w.operation    = op;
        w.power_value  = val;
        w.clamp_enable = clamp;
        pending_q.push_back(w);
    endtask

    // checked at the rising edge, where the driver outputs are settled
    task automatic drain();
        @(posedge i_clk);
        while (pending_q.size() != 0 || drv_valid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // driver: offers words at the falling edge, holds a word until taken
    always @(negedge i_clk) begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
        if (!drv_valid || in_taken) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                drv_data  <= pending_q.pop_front();
                drv_valid <= 1'b1;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // monitor: predicts on every accepted command, checks every accepted result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= drv_valid && !o_stall;
            if (o_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none pending, got %p", $time, o_data);
                end else begin
                    want = expected_q.pop_front();
                    if (o_data.pulse_width_ns !== want.pulse_width_ns) begin
                        errors++;
                        $display("%0t: pulse_width_ns expected %0d got %0d", $time,
                                 want.pulse_width_ns, o_data.pulse_width_ns);
                    end
                    if (o_data.running !== want.running) begin
                        errors++;
                        $display("%0t: running expected %0b got %0b", $time,
                                 want.running, o_data.running);
                    end
                    if (o_data.power_now !== want.power_now) begin
                        errors++;
                        $display("%0t: power_now expected %0d got %0d", $time,
                                 want.power_now, o_data.power_now);
                    end
                    if (o_data.duty_percent !== want.duty_percent) begin
                        errors++;
                        $display("%0t: duty_percent expected %0d got %0d", $time,
                                 want.duty_percent, o_data.duty_percent);
                    end
                end
            end
            if (drv_valid && !o_stall)
                expected_q.push_back(predict_pulse(drv_data));
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (drv_valid && !o_stall) || (o_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [WIDTH_W-1:0]       per, mn, mx, zr, st;
        logic signed [CTRL_W-1:0] lo, hi;
        logic [CTRL_W-1:0]        val;
        logic                     op;
        int                       a, b, v_lo, v_hi;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: off first, then range ends and out of range values
        queue_word(OP_POWER_OFF, 16'd0, 1'b0);
        queue_word(OP_SET_POWER, 16'd0, 1'b0);
        queue_word(OP_SET_POWER, 16'd100, 1'b0);
        queue_word(OP_SET_POWER, -16'sd100, 1'b0);
        queue_word(OP_SET_POWER, 16'h7FFF, 1'b1);
        queue_word(OP_SET_POWER, 16'h8000, 1'b1);
        queue_word(OP_SET_POWER, 16'h7FFF, 1'b0);
        queue_word(OP_SET_POWER, 16'h8000, 1'b0);
        queue_word(OP_POWER_OFF, 16'h7FFF, 1'b1);
        drain();

        // mirrored direction, zero period, stop width past the saturation point
        set_config('0, 30'd1000000, 30'd2000000, 30'd1500000, '1, -16'sd100, 16'sd100, 1'b1);
        queue_word(OP_SET_POWER, 16'd30, 1'b0);
        queue_word(OP_SET_POWER, -16'sd77, 1'b1);
        queue_word(OP_POWER_OFF, 16'hFFFF, 1'b0);
        drain();

        // zero span
        set_config(30'd20000000, 30'd1000000, 30'd2000000, 30'd1500000, 30'd7, -16'sd5,
                   -16'sd5, 1'b0);
        queue_word(OP_SET_POWER, 16'd1000, 1'b0);
        queue_word(OP_SET_POWER, 16'd1000, 1'b1);
        queue_word(OP_SET_POWER, -16'sd5, 1'b0);
        drain();

        // swapped bounds, negative span
        set_config(30'd20000000, 30'd1000000, 30'd2000000, 30'd1500000, 30'd0, 16'sd100,
                   -16'sd100, 1'b0);
        queue_word(OP_SET_POWER, 16'd200, 1'b1);
        queue_word(OP_SET_POWER, -16'sd200, 1'b1);
        queue_word(OP_SET_POWER, 16'd0, 1'b1);
        queue_word(OP_SET_POWER, 16'd50, 1'b0);
        drain();

        // falling slopes on both sides, period of one, full control range
        set_config(30'd1, 30'd900000000, 30'd0, 30'd500000, WIDTH_MAX, 16'h8000, 16'h7FFF,
                   1'b0);
        queue_word(OP_SET_POWER, 16'h8000, 1'b0);
        queue_word(OP_SET_POWER, 16'h7FFF, 1'b0);
        queue_word(OP_SET_POWER, 16'd0, 1'b1);
        queue_word(OP_POWER_OFF, 16'h5555, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p % 4)
                0:       begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_gap_pct = 49; recv_stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  recv_stall_pct = 49; end
                default: begin send_gap_pct = 16; recv_stall_pct = 16; end
            endcase

            if ($urandom_range(1)) begin
                mn = $urandom_range(1500000, 500000);
                mx = mn + $urandom_range(1500000);
                zr = (mn + mx) / 2;
            end else begin
                mn = pick_width();
                mx = pick_width();
                zr = pick_width();
            end
            st = pick_width();
            case ($urandom_range(5))
                0:       per = '0;
                1:       per = 30'd1;
                2:       per = 30'd20000000;
                3:       per = '1;
                4:       per = $urandom_range(3000000, 100000);
                default: per = $urandom;
            endcase
            case ($urandom_range(5))
                0:       begin lo = -16'sd100; hi = 16'sd100; end
                1:       begin lo = 16'h8000;  hi = 16'h7FFF; end
                2:       begin lo = $urandom;  hi = lo;       end
                3:       begin lo = 16'h7FFF;  hi = 16'h8000; end
                4:       begin lo = $urandom;  hi = $urandom; end
                default: begin lo = $urandom;  hi = lo + $urandom_range(10); end
            endcase
            set_config(per, mn, mx, zr, st, lo, hi, $urandom_range(1));

            a    = lo;
            b    = hi;
            v_lo = ((a < b) ? a : b) - 40;
            v_hi = ((a < b) ? b : a) + 40;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                op = ($urandom_range(99) < 15) ? OP_POWER_OFF : OP_SET_POWER;
                case ($urandom_range(9))
                    0, 1, 2, 3: val = $urandom;
                    4:          val = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
                    default:    val = v_lo + $urandom_range(v_hi - v_lo);
                endcase
                queue_word(op, val, $urandom_range(1));
            end
            drain();
        end

        repeat (200) @(negedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
